// ----- src/rfm_pkg.sv -----
// ----------------------------------------------------------------------------
// rfm_pkg: reciprocal frequency meter definitions
// Field widths, register indexes, phase codes and reset values.
// ----------------------------------------------------------------------------
package rfm_pkg;

	// fixed field widths
	localparam int FREQ_W    = 28;
	localparam int TIMEOUT_W = 20;
	localparam int TPS_W     = 20;
	localparam int THRESH_W  = 28;
	localparam int CFG_W     = 28;
	localparam int CFG_IDX_W = 2;

	// default parameter values
	localparam int COUNT_BITS_DEF    = 20;
	localparam int FRACTION_BITS_DEF = 8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TPS       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

	// register reset values
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 20'd500000;
	localparam logic [TPS_W-1:0]     TPS_RESET       = 20'd1000000;
	localparam logic [THRESH_W-1:0]  THRESHOLD_RESET = 28'd38400;

	// measurement phases
	localparam logic [1:0] PH_WAIT = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;

	typedef logic [FREQ_W-1:0] freq_t;

endpackage

// ----- src/rfm_if.sv -----
// ----------------------------------------------------------------------------
// rfm_if: request channels of the reciprocal frequency meter
// Sample channel carries one input level, result channel one measurement.
// ----------------------------------------------------------------------------
interface rfm_sample_if;
	logic valid;
	logic ready;
	logic level;

	modport source (output valid, output level, input ready);
	modport sink (input valid, input level, output ready);
endinterface

interface rfm_result_if;
	logic           valid;
	logic           ready;
	rfm_pkg::freq_t frequency_q8;
	logic           display_update;
	logic           timed_out;

	modport source (output valid, output frequency_q8, output display_update,
		output timed_out, input ready);
	modport sink (input valid, input frequency_q8, input display_update,
		input timed_out, output ready);
endinterface

// ----- src/reciprocal_frequency_meter.sv -----
// ----------------------------------------------------------------------------
// reciprocal_frequency_meter: edge-to-edge period meter with reciprocal output
// Counts ticks between rising edges of the sampled level, divides the tick
// rate by the period bit-serially and flags changes beyond a threshold.
// ----------------------------------------------------------------------------
//  channel   direction  payload                                        
//  samples   sink       level                                          
//  results   source     frequency_q8, display_update, timed_out        
//  cfg_*     write      cfg_index selects register, cfg_data value     
//
// a sample that gives no result leaves the block idle; the next is taken at once
// a closing edge goes through ST_DIV, the restoring divider that yields one
// quotient bit per cycle, then ST_CMP and ST_OUT; a timeout skips ST_DIV
// results sit in an output register, so the block goes on while it waits
// only the final load stalls when the output register is still full
// arst_n clears control state and loads register reset values
// ----------------------------------------------------------------------------
module reciprocal_frequency_meter #(
	parameter int COUNT_BITS    = rfm_pkg::COUNT_BITS_DEF,
	parameter int FRACTION_BITS = rfm_pkg::FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	rfm_sample_if.sink                    samples,
	rfm_result_if.source                  results,
	input  logic                          cfg_write,
	input  logic [rfm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rfm_pkg::CFG_W-1:0]     cfg_data
);

	localparam int FREQ_W  = rfm_pkg::FREQ_W;
	localparam int NUM_W   = rfm_pkg::TPS_W + FRACTION_BITS;
	localparam int DIV_W   = COUNT_BITS + 1;
	localparam int CMP_W   = (DIV_W > rfm_pkg::TIMEOUT_W) ? DIV_W : rfm_pkg::TIMEOUT_W;
	localparam int SAT_W   = (NUM_W > FREQ_W) ? NUM_W : FREQ_W;
	localparam int LAST_W  = FREQ_W + 1;
	localparam int DIFF_W  = FREQ_W + 2;
	localparam int CNT_W   = $clog2(NUM_W + 1);

	localparam logic [SAT_W-1:0] FREQ_MAX = SAT_W'({FREQ_W{1'b1}});
	localparam logic signed [LAST_W-1:0] LAST_RESET =
		LAST_W'(-(64'sd1 <<< FRACTION_BITS));
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(NUM_W);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_CMP  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	// configuration registers
	logic [rfm_pkg::TIMEOUT_W-1:0] timeout_q;
	logic [rfm_pkg::TPS_W-1:0]     tps_q;
	logic [rfm_pkg::THRESH_W-1:0]  thresh_q;

	// measurement state
	logic [1:0]              phase_q;
	logic                    prev_level_q;
	logic [COUNT_BITS-1:0]   tick_q;
	logic signed [LAST_W-1:0] last_q;

	// sequencer and divider
	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NUM_W-1:0]  num_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dvs_q;
	logic              timed_out_q;
	rfm_pkg::freq_t    freq_q;
	logic [DIFF_W-1:0] abs_q;

	// output register
	logic           res_valid_q;
	rfm_pkg::freq_t res_freq_q;
	logic           res_upd_q;
	logic           res_to_q;

	logic                  accept;
	logic                  rise;
	logic [1:0]            ph;
	logic [DIV_W-1:0]      period;
	logic                  tick_expired;
	logic                  period_over;
	logic [1:0]            phase_d;
	logic [COUNT_BITS-1:0] tick_d;
	logic                  emit;
	logic                  emit_to;

	logic [DIV_W:0]        trial;
	logic [DIV_W:0]        trial_sub;
	logic                  trial_ge;
	rfm_pkg::freq_t        freq_sat;
	logic signed [DIFF_W-1:0] diff;
	logic                  out_free;

	assign accept       = samples.valid && samples.ready;
	assign samples.ready = (state_q == ST_IDLE);

	assign rise         = samples.level && !prev_level_q;
	assign ph           = (phase_q == 2'd3) ? rfm_pkg::PH_WAIT : phase_q;
	assign period       = {1'b0, tick_q} + DIV_W'(1);
	assign tick_expired = CMP_W'(tick_q) >= CMP_W'(timeout_q);
	assign period_over  = CMP_W'(period) > CMP_W'(timeout_q);

	// next phase, count and result request for one sample
	always_comb begin
		phase_d = phase_q;
		tick_d  = (tick_q < COUNT_MAX) ? tick_q + COUNT_BITS'(1) : tick_q;
		emit    = 1'b0;
		emit_to = 1'b0;
		if (ph == rfm_pkg::PH_WAIT) begin
			if (rise) begin
				phase_d = rfm_pkg::PH_HIGH;
				tick_d  = '0;
			end else if (tick_expired) begin
				emit    = 1'b1;
				emit_to = 1'b1;
				phase_d = rfm_pkg::PH_WAIT;
				tick_d  = '0;
			end else begin
				phase_d = rfm_pkg::PH_WAIT;
			end
		end else if (ph == rfm_pkg::PH_LOW && samples.level) begin
			// closing rise opens the next measurement
			emit    = 1'b1;
			emit_to = period_over;
			phase_d = rfm_pkg::PH_HIGH;
			tick_d  = '0;
		end else if (tick_expired) begin
			emit    = 1'b1;
			emit_to = 1'b1;
			phase_d = rfm_pkg::PH_WAIT;
			tick_d  = '0;
		end else if (ph == rfm_pkg::PH_HIGH && !samples.level) begin
			phase_d = rfm_pkg::PH_LOW;
		end
	end

	// restoring divide step
	assign trial     = {rem_q, num_q[NUM_W-1]};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign trial_ge  = trial >= {1'b0, dvs_q};

	assign freq_sat = (SAT_W'(num_q) > FREQ_MAX) ? FREQ_MAX[FREQ_W-1:0] : FREQ_W'(num_q);
	assign diff     = DIFF_W'(signed'({1'b0, freq_sat})) - DIFF_W'(last_q);
	assign out_free = !res_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= rfm_pkg::TIMEOUT_RESET;
			tps_q     <= rfm_pkg::TPS_RESET;
			thresh_q  <= rfm_pkg::THRESHOLD_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				rfm_pkg::REG_TIMEOUT:   timeout_q <= cfg_data[rfm_pkg::TIMEOUT_W-1:0];
				rfm_pkg::REG_TPS:       tps_q     <= cfg_data[rfm_pkg::TPS_W-1:0];
				rfm_pkg::REG_THRESHOLD: thresh_q  <= cfg_data[rfm_pkg::THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= rfm_pkg::PH_WAIT;
			prev_level_q <= 1'b1;
			tick_q       <= '0;
			last_q       <= LAST_RESET;
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			num_q        <= '0;
			rem_q        <= '0;
			dvs_q        <= '0;
			timed_out_q  <= 1'b0;
			freq_q       <= '0;
			abs_q        <= '0;
			res_valid_q  <= 1'b0;
			res_freq_q   <= '0;
			res_upd_q    <= 1'b0;
			res_to_q     <= 1'b0;
		end else begin
			// a load in ST_OUT takes precedence over the clear
			if (results.ready && state_q != ST_OUT) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_level_q <= samples.level;
						phase_q      <= phase_d;
						tick_q       <= tick_d;
						if (emit) begin
							timed_out_q <= emit_to;
							if (emit_to) begin
								num_q   <= '0;
								state_q <= ST_CMP;
							end else begin
								num_q   <= NUM_W'(tps_q) << FRACTION_BITS;
								rem_q   <= '0;
								dvs_q   <= period;
								cnt_q   <= DIV_STEPS;
								state_q <= ST_DIV;
							end
						end
					end
				end
				ST_DIV: begin
					num_q <= {num_q[NUM_W-2:0], trial_ge};
					rem_q <= trial_ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					freq_q  <= freq_sat;
					abs_q   <= diff[DIFF_W-1] ? -diff : diff;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_freq_q  <= freq_q;
						res_to_q    <= timed_out_q;
						res_upd_q   <= abs_q > DIFF_W'(thresh_q);
						if (abs_q > DIFF_W'(thresh_q)) begin
							last_q <= signed'({1'b0, freq_q});
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign results.valid          = res_valid_q;
	assign results.frequency_q8   = res_freq_q;
	assign results.display_update = res_upd_q;
	assign results.timed_out      = res_to_q;

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the reciprocal frequency meter
// Sends sampled levels as ticks and predicts period, reciprocal and change
// flag. Each result is checked field by field against the oldest prediction,
// over several register settings, with random idling and back-pressure.
// ----------------------------------------------------------------------------
import rfm_pkg::*;

typedef struct packed {
	freq_t frequency_q8;
	logic  display_update;
	logic  timed_out;
} reading_t;

class meter_scoreboard;
	localparam longint FREQ_LIMIT = (longint'(1) << FREQ_W) - 1;

	bit [TIMEOUT_W-1:0]      timeout_ticks;
	bit [TPS_W-1:0]          ticks_per_second;
	bit [THRESH_W-1:0]       change_threshold;
	bit [1:0]                phase;
	bit                      prev_level;
	bit [COUNT_BITS_DEF-1:0] tick_count;
	longint                  last_flagged;
	reading_t                pending_readings[$];
	int                      errors;

	function new();
		timeout_ticks    = TIMEOUT_RESET;
		ticks_per_second = TPS_RESET;
		change_threshold = THRESHOLD_RESET;
		phase            = PH_WAIT;
		prev_level       = 1'b1;
		tick_count       = '0;
		last_flagged     = -(longint'(1) << FRACTION_BITS_DEF);
		errors           = 0;
	endfunction

	function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		case (idx)
			REG_TIMEOUT:   timeout_ticks = data[TIMEOUT_W-1:0];
			REG_TPS:       ticks_per_second = data[TPS_W-1:0];
			REG_THRESHOLD: change_threshold = data[THRESH_W-1:0];
			default: ;
		endcase
	endfunction

	function freq_t reciprocal(longint period);
		longint q;
		if (period == 0)
			return '0;
		q = (longint'(ticks_per_second) << FRACTION_BITS_DEF) / period;
		if (q > FREQ_LIMIT)
			q = FREQ_LIMIT;
		return freq_t'(q);
	endfunction

	function void queue_reading(freq_t freq, bit from_timeout);
		reading_t r;
		longint   d;
		d = longint'(freq) - last_flagged;
		if (d < 0)
			d = -d;
		r.frequency_q8   = freq;
		r.display_update = 1'b0;
		r.timed_out      = from_timeout;
		if (d > longint'(change_threshold)) begin
			last_flagged = longint'(freq);
			r.display_update = 1'b1;
		end
		pending_readings.push_back(r);
	endfunction

	function void advance_count();
		if (tick_count != '1)
			tick_count++;
	endfunction

	// one accepted tick
	function void note_sample(bit lvl);
		bit     rise;
		longint period;
		rise = lvl && !prev_level;
		prev_level = lvl;
		// anything other than high or low behaves as waiting for a rise
		if (phase != PH_HIGH && phase != PH_LOW) begin
			if (rise) begin
				phase = PH_HIGH;
				tick_count = '0;
			end else if (tick_count >= timeout_ticks) begin
				queue_reading('0, 1'b1);
				phase = PH_WAIT;
				tick_count = '0;
			end else begin
				phase = PH_WAIT;
				advance_count();
			end
			return;
		end
		// closing rise also opens the next measurement
		if (phase == PH_LOW && lvl) begin
			period = longint'(tick_count) + 1;
			if (period > longint'(timeout_ticks))
				queue_reading('0, 1'b1);
			else
				queue_reading(reciprocal(period), 1'b0);
			phase = PH_HIGH;
			tick_count = '0;
			return;
		end
		if (tick_count >= timeout_ticks) begin
			queue_reading('0, 1'b1);
			phase = PH_WAIT;
			tick_count = '0;
			return;
		end
		advance_count();
		if (phase == PH_HIGH && !lvl)
			phase = PH_LOW;
	endfunction

	task report(string what);
		if (errors < 100)
			$display("mismatch: %s", what);
		errors++;
	endtask

	task check_result(reading_t got);
		reading_t want;
		if (pending_readings.size() == 0) begin
			report($sformatf("result with none pending, frequency_q8 %0d",
				got.frequency_q8));
			return;
		end
		want = pending_readings.pop_front();
		if (got.frequency_q8 !== want.frequency_q8)
			report($sformatf("frequency_q8 %0d, predicted %0d",
				got.frequency_q8, want.frequency_q8));
		if (got.display_update !== want.display_update)
			report($sformatf("display_update %b, predicted %b",
				got.display_update, want.display_update));
		if (got.timed_out !== want.timed_out)
			report($sformatf("timed_out %b, predicted %b",
				got.timed_out, want.timed_out));
	endtask
endclass

module tb;
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   idle_pct = 32;
	int                   hold_requests = 0;
	meter_scoreboard      sb = new();

	rfm_sample_if samples_if();
	rfm_result_if results_if();

	reciprocal_frequency_meter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_if),
		.results   (results_if),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	initial begin
		#2400000;
		$display("CHECKS FAILED");
		$finish;
	end

	// result side: check accepted results, stall at random or on a hold request
	initial begin
		int holds_served;
		int hold_left;
		holds_served = 0;
		hold_left = 0;
		results_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (results_if.valid && results_if.ready)
				sb.check_result({results_if.frequency_q8, results_if.display_update,
					results_if.timed_out});
			if (hold_left == 0 && holds_served != hold_requests) begin
				hold_left = 400;
				holds_served++;
			end
			if (hold_left > 0) begin
				results_if.ready <= 1'b0;
				hold_left--;
			end else begin
				results_if.ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	task automatic send_level(bit lvl);
		while ($urandom_range(99) < idle_pct) begin
			samples_if.valid <= 1'b0;
			samples_if.level <= 1'($urandom);
			@(posedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.level <= lvl;
		do
			@(posedge clk);
		while (!samples_if.ready);
		sb.note_sample(lvl);
	endtask

	// msb first
	task automatic send_bits(int n, logic [31:0] bits);
		for (int i = n - 1; i >= 0; i--)
			send_level(bits[i]);
	endtask

	task automatic pause_until_drained();
		samples_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending_readings.size() != 0);
	endtask

	// a tick that gives no result may still be in flight when the queue empties
	task automatic settle();
		pause_until_drained();
		repeat (64) @(posedge clk);
	endtask

	task automatic put_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_register(idx, data);
	endtask

	task automatic configure(bit [TIMEOUT_W-1:0] t, bit [TPS_W-1:0] tps,
		bit [THRESH_W-1:0] thr);
		put_register(REG_TIMEOUT, CFG_W'(t));
		put_register(REG_TPS, CFG_W'(tps));
		put_register(REG_THRESHOLD, CFG_W'(thr));
		cfg_write <= 1'b0;
	endtask

	// mostly clean square waves, some held levels and some noise
	task automatic drive_waveform(int count);
		int sent;
		int span;
		int high_len;
		int low_len;
		int choice;
		bit lvl;
		sent = 0;
		span = (sb.timeout_ticks < 30) ? int'(sb.timeout_ticks) + 2 : 30;
		while (sent < count) begin
			choice = $urandom_range(99);
			if (choice < 80) begin
				high_len = $urandom_range(span, 1);
				low_len = $urandom_range(span, 1);
				for (int i = 0; i < high_len + low_len && sent < count; i++) begin
					send_level(i < high_len);
					sent++;
				end
			end else if (choice < 90) begin
				// held level, at times long enough to run into a timeout
				lvl = 1'($urandom);
				high_len = $urandom_range(2 * span + 2, 1);
				for (int i = 0; i < high_len && sent < count; i++) begin
					send_level(lvl);
					sent++;
				end
			end else begin
				high_len = $urandom_range(8, 1);
				for (int i = 0; i < high_len && sent < count; i++) begin
					send_level(1'($urandom));
					sent++;
				end
			end
		end
	endtask

	initial begin
		samples_if.valid = 1'b0;
		samples_if.level = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_TIMEOUT;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// register reset values, no edge at start, repeated period gives no flag
		send_bits(11, 11'b10110010101);
		settle();
		// zero timeout and zero rate: timeouts in high and wait, rise still opens
		configure('0, '0, '0);
		send_bits(6, 6'b001101);
		settle();
		// timeout in low, in-range closing rise, closing rise past the timeout
		configure(20'd2, '1, '1);
		send_bits(9, 9'b000101001);
		settle();

		for (int p = 0; p < 8; p++) begin
			idle_pct = 32;
			case (p)
				0: configure(20'd1, 20'd1, '0);
				1: configure(TIMEOUT_W'($urandom_range(40, 2)),
					TPS_W'($urandom_range(1000000, 1)),
					THRESH_W'($urandom_range(50000, 0)));
				2: configure('1, 20'd1000000, 28'd38400);
				3: configure(TIMEOUT_W'($urandom_range(40, 4)), '1, '1);
				4: configure('0, TPS_W'($urandom_range(1000000, 1)),
					THRESH_W'($urandom_range(1000, 0)));
				5: configure(TIMEOUT_W'($urandom_range(12, 1)), '0, '0);
				6: configure(TIMEOUT_W'($urandom_range(60, 2)),
					TPS_W'($urandom_range(1048575, 0)), 28'($urandom));
				default: configure(TIMEOUT_W'($urandom_range(40, 2)), 20'd1000000,
					28'd38400);
			endcase
			if (p == 2) begin
				// no idling here, and one long hold-off on the result side
				idle_pct = 0;
				hold_requests++;
			end
			if (p == 7) begin
				drive_waveform(95);
				pause_until_drained();
				drive_waveform(100);
			end else begin
				drive_waveform(195);
			end
			settle();
		end

		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ----- files.f -----
src/rfm_pkg.sv
src/rfm_if.sv
src/reciprocal_frequency_meter.sv
tb/sv/tb.sv
